// ----- hdl/hpq_pkg.sv -----
// Shared types and constants of the indexed max-priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package hpq_pkg;

    localparam int SLOT_W    = 4;
    localparam int IN_KEY_W  = 32;
    localparam int OUT_KEY_W = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CHANGE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_ABSENT = 3'd3,
        ST_DUP    = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_INS_INIT,
        OP_CHG_INIT,
        OP_RD_TOP,
        OP_REM_TOP,
        OP_LOAD_E,
        OP_RD_SLOT,
        OP_RD_OUT,
        OP_UP_RD,
        OP_UP_MOVE,
        OP_DN_RD1,
        OP_DN_TAKE1,
        OP_DN_PICK,
        OP_DN_MOVE,
        OP_PUT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic  fail;
        t_mode mode;
        logic  p_zero;
        logic  up_gt;
        logic  moved;
        logic  chg;
        logic  dn_has;
        logic  dn_gt;
        logic  cnt_zero;
        logic  out_free;
    } t_dp_stat;

endpackage

// ----- hdl/hpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/hpq_ctrl.sv -----
// Sequencing state machine of the priority queue: walks a request through
// check, remove or read, sift-up, sift-down and emit steps. Depends on hpq_pkg.
module hpq_ctrl
    import hpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    input  t_dp_stat i_stat,
    output logic     o_s_ready,
    output t_op      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_REM_TOP, S_REM_LAST, S_RD_LOAD, S_UP_TEST, S_UP_CMP,
        S_UP_END, S_DN_TEST, S_DN_C1, S_DN_C2, S_DN_CMP, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd   = OP_LATCH;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.fail) begin
                    n_state = S_FIN;
                end else begin
                    unique case (i_stat.mode)
                        MODE_INSERT: begin
                            o_cmd   = OP_INS_INIT;
                            n_state = S_UP_TEST;
                        end
                        MODE_REMOVE: begin
                            o_cmd   = OP_RD_TOP;
                            n_state = S_REM_TOP;
                        end
                        MODE_CHANGE: begin
                            o_cmd   = OP_CHG_INIT;
                            n_state = S_UP_TEST;
                        end
                        default: begin
                            o_cmd   = OP_RD_SLOT;
                            n_state = S_RD_LOAD;
                        end
                    endcase
                end
            end
            S_REM_TOP: begin
                o_cmd   = OP_REM_TOP;
                n_state = S_REM_LAST;
            end
            S_REM_LAST: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = OP_LOAD_E;
                    n_state = S_DN_TEST;
                end
            end
            S_RD_LOAD: begin
                o_cmd   = OP_RD_OUT;
                n_state = S_FIN;
            end
            S_UP_TEST: begin
                if (i_stat.p_zero) begin
                    n_state = S_UP_END;
                end else begin
                    o_cmd   = OP_UP_RD;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_gt) begin
                    o_cmd   = OP_UP_MOVE;
                    n_state = S_UP_TEST;
                end else begin
                    n_state = S_UP_END;
                end
            end
            S_UP_END: begin
                // A changed key that did not rise may still have to sink.
                if (i_stat.chg && !i_stat.moved) begin
                    n_state = S_DN_TEST;
                end else begin
                    o_cmd   = OP_PUT;
                    n_state = S_FIN;
                end
            end
            S_DN_TEST: begin
                if (i_stat.dn_has) begin
                    o_cmd   = OP_DN_RD1;
                    n_state = S_DN_C1;
                end else begin
                    o_cmd   = OP_PUT;
                    n_state = S_FIN;
                end
            end
            S_DN_C1: begin
                o_cmd   = OP_DN_TAKE1;
                n_state = S_DN_C2;
            end
            S_DN_C2: begin
                o_cmd   = OP_DN_PICK;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_gt) begin
                    o_cmd   = OP_DN_MOVE;
                    n_state = S_DN_TEST;
                end else begin
                    o_cmd   = OP_PUT;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd   = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/hpq_dp.sv -----
// Datapath of the priority queue: heap RAM, slot position table, held entry
// and result register. Depends on hpq_pkg and hpq_ram.
module hpq_dp
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_op                  i_cmd,
    input  t_mode                i_mode,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [IN_KEY_W-1:0]  i_key,
    input  logic                 i_m_ready,
    output t_dp_stat             o_stat,
    output logic                 o_valid,
    output logic [OUT_KEY_W-1:0] o_key,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_present,
    output t_status              o_status,
    output logic [CNT_OUT_W-1:0] o_count
);

    localparam int NSLOT = (CAPACITY < (1 << SLOT_W)) ? CAPACITY : (1 << SLOT_W);
    localparam int SLW   = $clog2(NSLOT);
    localparam int PW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EW    = SLOT_W + KEY_BITS;

    t_mode                r_mode;
    logic [SLOT_W-1:0]    r_slot;
    logic [KEY_BITS-1:0]  r_key;
    t_status              r_stat;
    logic [CW-1:0]        r_cnt;
    logic [NSLOT-1:0]     r_valid;
    logic [PW-1:0]        r_pos [NSLOT];
    logic [EW-1:0]        r_e;
    logic [EW-1:0]        r_c;
    logic [PW-1:0]        r_p;
    logic [PW-1:0]        r_ci;
    logic                 r_moved;
    logic                 r_chg;
    logic [OUT_KEY_W-1:0] r_okey;
    logic [SLOT_W-1:0]    r_oslot;

    logic                 w_we;
    logic [PW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic [PW-1:0]        w_raddr;
    logic [EW-1:0]        w_rdata;
    logic [KEY_BITS-1:0]  w_in_key;
    logic [KEY_BITS-1:0]  w_rd_key;
    logic [OUT_KEY_W-1:0] w_rd_k32;
    logic [PW-1:0]        w_par;
    logic [PW+1:0]        w_c1;
    logic [PW+1:0]        w_c2;
    logic                 w_in_rng;
    logic                 w_here;
    logic                 w_c2_better;
    t_status              w_err;

    hpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    generate
        if (KEY_BITS <= IN_KEY_W) begin : g_kin_narrow
            assign w_in_key = i_key[KEY_BITS-1:0];
        end else begin : g_kin_wide
            assign w_in_key = {{(KEY_BITS-IN_KEY_W){i_key[IN_KEY_W-1]}}, i_key};
        end
        if (KEY_BITS >= OUT_KEY_W) begin : g_kout_wide
            assign w_rd_k32 = w_rd_key[OUT_KEY_W-1:0];
        end else begin : g_kout_narrow
            assign w_rd_k32 = {{(OUT_KEY_W-KEY_BITS){w_rd_key[KEY_BITS-1]}}, w_rd_key};
        end
    endgenerate

    assign w_rd_key = w_rdata[EW-1:SLOT_W];
    assign w_par    = PW'((r_p - 1'b1) >> 1);
    assign w_c1     = {1'b0, r_p, 1'b1};
    assign w_c2     = w_c1 + 1'b1;

    // Status checks run on the incoming request while the queue is idle.
    assign w_in_rng = (32'(i_slot) < CAPACITY);
    assign w_here   = w_in_rng && r_valid[i_slot[SLW-1:0]];

    always_comb begin
        w_err = ST_OK;
        unique case (i_mode)
            MODE_INSERT: begin
                if (!w_in_rng)                 w_err = ST_ABSENT;
                else if (w_here)               w_err = ST_DUP;
                else if (32'(r_cnt) >= CAPACITY) w_err = ST_FULL;
            end
            MODE_REMOVE: begin
                if (r_cnt == '0) w_err = ST_EMPTY;
            end
            default: begin
                if (!w_here) w_err = ST_ABSENT;
            end
        endcase
    end

    assign w_c2_better = ((PW+2)'(r_cnt) > w_c2) &&
                         ($signed(r_c[EW-1:SLOT_W]) < $signed(w_rd_key));

    always_comb begin
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = r_p;
        w_wdata = r_e;
        unique case (i_cmd)
            OP_REM_TOP:  w_raddr = PW'(r_cnt - 1'b1);
            OP_RD_SLOT:  w_raddr = r_pos[r_slot[SLW-1:0]];
            OP_UP_RD:    w_raddr = w_par;
            OP_DN_RD1:   w_raddr = w_c1[PW-1:0];
            OP_DN_TAKE1: w_raddr = w_c2[PW-1:0];
            OP_UP_MOVE: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            OP_DN_MOVE: begin
                w_we    = 1'b1;
                w_wdata = r_c;
            end
            OP_PUT:      w_we = 1'b1;
            default:     w_raddr = '0;
        endcase
    end

    always_comb begin
        o_stat.fail     = (r_stat != ST_OK);
        o_stat.mode     = r_mode;
        o_stat.p_zero   = (r_p == '0);
        o_stat.up_gt    = $signed(w_rd_key) < $signed(r_e[EW-1:SLOT_W]);
        o_stat.moved    = r_moved;
        o_stat.chg      = r_chg;
        o_stat.dn_has   = ((PW+2)'(r_cnt) > w_c1);
        o_stat.dn_gt    = $signed(r_e[EW-1:SLOT_W]) < $signed(r_c[EW-1:SLOT_W]);
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.out_free = !o_valid || i_m_ready;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            OP_LATCH: begin
                r_mode  <= i_mode;
                r_slot  <= i_slot;
                r_key   <= w_in_key;
                r_stat  <= w_err;
                r_okey  <= '0;
                r_oslot <= i_slot;
                r_moved <= 1'b0;
                r_chg   <= 1'b0;
            end
            OP_INS_INIT: begin
                r_e <= {r_key, r_slot};
                r_p <= r_cnt[PW-1:0];
            end
            OP_CHG_INIT: begin
                r_e   <= {r_key, r_slot};
                r_p   <= r_pos[r_slot[SLW-1:0]];
                r_chg <= 1'b1;
            end
            OP_REM_TOP: begin
                r_okey  <= w_rd_k32;
                r_oslot <= w_rdata[SLOT_W-1:0];
            end
            OP_LOAD_E: begin
                r_e <= w_rdata;
                r_p <= '0;
            end
            OP_RD_OUT:  r_okey <= w_rd_k32;
            OP_UP_MOVE: begin
                r_pos[w_rdata[SLW-1:0]] <= r_p;
                r_p     <= w_par;
                r_moved <= 1'b1;
            end
            OP_DN_TAKE1: begin
                r_c  <= w_rdata;
                r_ci <= w_c1[PW-1:0];
            end
            OP_DN_PICK: begin
                if (w_c2_better) begin
                    r_c  <= w_rdata;
                    r_ci <= w_c2[PW-1:0];
                end
            end
            OP_DN_MOVE: begin
                r_pos[r_c[SLW-1:0]] <= r_p;
                r_p <= r_ci;
            end
            OP_PUT:     r_pos[r_e[SLW-1:0]] <= r_p;
            OP_EMIT: begin
                o_key     <= r_okey;
                o_slot    <= r_oslot;
                o_present <= (32'(r_oslot) < CAPACITY) && r_valid[r_oslot[SLW-1:0]];
                o_status  <= r_stat;
                o_count   <= CNT_OUT_W'(r_cnt);
            end
            default: r_p <= r_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd == OP_INS_INIT) begin
                r_cnt                   <= r_cnt + 1'b1;
                r_valid[r_slot[SLW-1:0]] <= 1'b1;
            end else if (i_cmd == OP_REM_TOP) begin
                r_cnt                         <= r_cnt - 1'b1;
                r_valid[w_rdata[SLW-1:0]]     <= 1'b0;
            end
            if (i_cmd == OP_EMIT) begin
                o_valid <= 1'b1;
            end else if (i_m_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CAPACITY)
        else $error("entry count above capacity");

    a_cnt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_cnt))
        else $error("entry count disagrees with present slots");

    a_fail_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == OP_EMIT && r_stat != ST_OK) |=> (o_key == '0))
        else $error("failed request returned a nonzero key");

endmodule

// ----- hdl/indexed_max_priority_queue.sv -----
// Indexed max-priority queue: one request at a time. Sift-up and sift-down
// walk the heap through the single read port of the heap RAM, and a request
// waits in its finish state until the output register is free. A result
// waits in the output register while the next request is accepted. No reset
// sweep needed.
module indexed_max_priority_queue
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // slot[3:0], key[35:4], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // out_key, out_slot, present, status, count, pad
);

    t_op                  w_cmd;
    t_dp_stat             w_stat;
    logic [OUT_KEY_W-1:0] w_key;
    logic [SLOT_W-1:0]    w_slot;
    logic                 w_present;
    t_status              w_status;
    logic [CNT_OUT_W-1:0] w_count;

    hpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_stat    (w_stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    hpq_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_mode    (t_mode'(s_axis_tuser)),
        .i_slot    (s_axis_tdata[3:0]),
        .i_key     (s_axis_tdata[35:4]),
        .i_m_ready (m_axis_tready),
        .o_stat    (w_stat),
        .o_valid   (m_axis_tvalid),
        .o_key     (w_key),
        .o_slot    (w_slot),
        .o_present (w_present),
        .o_status  (w_status),
        .o_count   (w_count)
    );

    assign m_axis_tdata = {3'b000, w_count, w_status, w_present, w_slot, w_key};

endmodule
